// ===== rtl/frame_difference_motion_mask_top_macros.svh =====
// Assertion shorthands shared by the motion mask RTL.
// Each use expects aclk and aresetn in scope of the including module.
`ifndef FRAME_DIFFERENCE_MOTION_MASK_TOP_MACROS_SVH
`define FRAME_DIFFERENCE_MOTION_MASK_TOP_MACROS_SVH

// same-cycle implication
`define FDMM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FDMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fdmm_pkg.sv =====
// Shared types and constants for the frame difference motion mask.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fdmm_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int MEDIAN_SIZE  = 5;

    localparam int PIX_W       = 8;
    localparam int LINE_SLOTS  = MEDIAN_SIZE;
    localparam int WIN_TAPS    = MEDIAN_SIZE * MEDIAN_SIZE;
    localparam int MEDIAN_RANK = WIN_TAPS / 2;
    localparam int RANK_W      = $clog2(WIN_TAPS);
    localparam int COL_W       = $clog2(FRAME_WIDTH);
    localparam int ROW_W       = $clog2(FRAME_HEIGHT + 3);
    localparam int SLOT_W      = $clog2(LINE_SLOTS);
    localparam int ADDR_W      = 4;

    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'((FRAME_HEIGHT - 1) % LINE_SLOTS);

    localparam logic [PIX_W-1:0] DIFF_THR_RESET = 8'd30;
    localparam logic [PIX_W-1:0] BG_THR_RESET   = 8'd30;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        REG_DIFF_THR = 2'd0,
        REG_BG_THR   = 2'd1,
        REG_BG_EN    = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        POS_MID = 3'd0,
        POS_L0  = 3'd1,
        POS_L1  = 3'd2,
        POS_R1  = 3'd3,
        POS_R0  = 3'd4
    } col_pos_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [WIN_TAPS-1:0] window_t;

    typedef struct packed {
        logic op;
        pix_t current_pixel;
        pix_t previous_pixel;
        pix_t background_pixel;
    } in_item_t;

    typedef struct packed {
        logic motion;
        logic frame_end;
    } out_item_t;

    typedef struct packed {
        logic en_cmp;
        logic en_rank;
        logic en_sel;
    } med_ctl_t;

endpackage

// ===== rtl/fdmm_median5x5.sv =====
// Three-stage rank-based median of a 25-pixel window.
// Depends on fdmm_pkg; stage enables come from the owner's pipeline.
`timescale 1ns / 1ps

module fdmm_median5x5 (
    input  logic              aclk,
    input  fdmm_pkg::med_ctl_t ctl,
    input  fdmm_pkg::window_t win,
    output fdmm_pkg::pix_t    median
);
    import fdmm_pkg::*;

    logic [WIN_TAPS-1:0] le_next [WIN_TAPS];
    logic [WIN_TAPS-1:0] le_reg  [WIN_TAPS];
    logic [RANK_W-1:0]   rank_next [WIN_TAPS];
    logic [RANK_W-1:0]   rank_reg  [WIN_TAPS];
    window_t             win_a_reg;
    window_t             win_b_reg;
    pix_t                med_next;
    pix_t                med_reg;

    // pairwise compares, lower index wins ties
    always_comb begin
        for (int i = 0; i < WIN_TAPS; i++) begin
            for (int j = 0; j < WIN_TAPS; j++) begin
                le_next[i][j] = (j < i) ? (win[j] <= win[i]) : 1'b0;
            end
        end
    end

    always_comb begin
        logic [WIN_TAPS-1:0] ahead;
        ahead = '0;
        for (int i = 0; i < WIN_TAPS; i++) begin
            for (int j = 0; j < WIN_TAPS; j++) begin
                if (j < i) begin
                    ahead[j] = le_reg[i][j];
                end else if (j > i) begin
                    ahead[j] = !le_reg[j][i];
                end else begin
                    ahead[j] = 1'b0;
                end
            end
            rank_next[i] = RANK_W'($countones(ahead));
        end
    end

    // ranks form a permutation, so exactly one tap matches
    always_comb begin
        med_next = '0;
        for (int i = 0; i < WIN_TAPS; i++) begin
            if (rank_reg[i] == RANK_W'(MEDIAN_RANK)) begin
                med_next = med_next | win_b_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en_cmp) begin
            le_reg    <= le_next;
            win_a_reg <= win;
        end
        if (ctl.en_rank) begin
            rank_reg  <= rank_next;
            win_b_reg <= win_a_reg;
        end
        if (ctl.en_sel) begin
            med_reg <= med_next;
        end
    end

    assign median = med_reg;

endmodule

// ===== rtl/frame_difference_motion_mask_top.sv =====
// Top level of the frame difference motion mask.
// Depends on fdmm_pkg, fdmm_median5x5 and the assertion macro header.
`timescale 1ns / 1ps
`include "frame_difference_motion_mask_top_macros.svh"

// Usage
//   s_* carries one request per raster position: op 0 is a pixel (current,
//   previous and background grey values), op 1 a flush tick with no pixel.
//   m_* returns one mask bit per centre pixel; frame_end flags the frame's
//   final centre. Results trail their centre by 2*FRAME_WIDTH+2 requests;
//   after the last pixel of a frame, that many flush ticks drain the tail.
//   Flush ticks with nothing to drain are taken and dropped.
//   Throughput is one request per clock when the pipeline is not stalled, set by
//   the column read-modify-write of the line memory (one read and one write port)
//   and the eight-stage pipeline. A result sits on m_data, in the output register,
//   once the request that completes it has passed through every stage.
//   The APB port sets both thresholds and the background enable; write it
//   only while the block is idle. pready is tied high.
//   Reset (aresetn low, synchronous) clears position counters, pipeline
//   valids and the registers to their defaults; line memory is left as is.
//   When m_ready is low, stages fill up behind the output register and
//   s_ready drops only once every stage holds a request.

module frame_difference_motion_mask_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fdmm_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output fdmm_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fdmm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import fdmm_pkg::*;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic                   pixel;
        pix_t                   cur;
        pix_t                   prev;
        pix_t                   bg;
        logic [COL_W-1:0]       col;
        slot_t                  wslot;
        slot_t [LINE_SLOTS-1:0] sel;
        logic                   emit;
        logic                   frame_end;
        col_pos_t               colpos;
    } step_t;

    typedef struct packed {
        pix_t cur;
        pix_t prev;
        pix_t bg;
    } slot_word_t;

    typedef slot_word_t [LINE_SLOTS-1:0] line_word_t;

    typedef struct packed {
        pix_t [LINE_SLOTS-1:0] cur;
        pix_t [LINE_SLOTS-1:0] prev;
        pix_t                  bg;
    } col_vec_t;

    function automatic logic [2:0] tap_of(col_pos_t p, int m);
        int t;
        t = m;
        case (p)
            POS_L0:  t = (m < 2) ? 2 : m;
            POS_L1:  t = (m < 1) ? 1 : m;
            POS_R1:  t = (m > 3) ? 3 : m;
            POS_R0:  t = (m > 2) ? 2 : m;
            default: t = m;
        endcase
        return 3'(t);
    endfunction

    function automatic pix_t abs_diff(pix_t a, pix_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // ---------------- configuration ----------------
    pix_t     diff_thr_reg;
    pix_t     bg_thr_reg;
    logic     bg_en_reg;
    logic     cfg_wr;
    cfg_reg_t cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_thr_reg <= DIFF_THR_RESET;
            bg_thr_reg   <= BG_THR_RESET;
            bg_en_reg    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                REG_DIFF_THR: diff_thr_reg <= pwdata[PIX_W-1:0];
                REG_BG_THR:   bg_thr_reg   <= pwdata[PIX_W-1:0];
                REG_BG_EN:    bg_en_reg    <= pwdata[0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_sel)
            REG_DIFF_THR: prdata = {24'd0, diff_thr_reg};
            REG_BG_THR:   prdata = {24'd0, bg_thr_reg};
            REG_BG_EN:    prdata = {31'd0, bg_en_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // stage i may load when it is empty or its contents move on
    logic [8:1] vld_reg;
    logic [8:1] en;

    always_comb begin
        en[8] = !vld_reg[8] || m_ready;
        for (int i = 7; i >= 1; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign s_ready = en[1];

    // ---------------- position tracking ----------------
    // Virtual raster position of the next step; rows FRAME_HEIGHT and up
    // are the drain tail, walked by flush ticks.
    logic [ROW_W-1:0] vr_reg;
    logic [COL_W-1:0] vc_reg;
    slot_t            vs_reg;

    logic             is_pixel;
    logic             in_tail;
    logic             pending;
    logic             take;
    logic [ROW_W-1:0] er;
    logic [COL_W-1:0] ec;
    slot_t            es;
    logic [ROW_W-1:0] vr_next;
    logic [COL_W-1:0] vc_next;
    slot_t            vs_next;
    logic [COL_W-1:0] centre_col;
    step_t            s1_next;

    assign is_pixel = (s_data.op == OP_PIXEL);
    assign in_tail  = (vr_reg >= ROW_W'(FRAME_HEIGHT));
    assign pending  = in_tail &&
                      !((vr_reg == ROW_W'(FRAME_HEIGHT + 2)) && (vc_reg >= COL_W'(2)));
    assign take     = s_valid && en[1] && (is_pixel || pending);

    always_comb begin
        logic [SLOT_W:0] t;
        // a pixel in the tail starts a new frame, dropping the rest
        if (is_pixel && in_tail) begin
            er = '0;
            ec = '0;
            es = '0;
        end else begin
            er = vr_reg;
            ec = vc_reg;
            es = vs_reg;
        end

        if (ec == COL_W'(FRAME_WIDTH - 1)) begin
            vc_next = '0;
            vr_next = er + ROW_W'(1);
            vs_next = (es == slot_t'(LINE_SLOTS - 1)) ? '0 : es + slot_t'(1);
        end else begin
            vc_next = ec + COL_W'(1);
            vr_next = er;
            vs_next = es;
        end

        centre_col = (ec >= COL_W'(2)) ? (ec - COL_W'(2)) : (ec + COL_W'(FRAME_WIDTH - 2));

        s1_next.pixel     = is_pixel;
        s1_next.cur       = s_data.current_pixel;
        s1_next.prev      = s_data.previous_pixel;
        s1_next.bg        = s_data.background_pixel;
        s1_next.col       = ec;
        s1_next.wslot     = es;
        s1_next.emit      = (er > ROW_W'(2)) || ((er == ROW_W'(2)) && (ec >= COL_W'(2)));
        s1_next.frame_end = (er == ROW_W'(FRAME_HEIGHT + 2)) && (ec == COL_W'(1));

        if (centre_col == COL_W'(0)) begin
            s1_next.colpos = POS_L0;
        end else if (centre_col == COL_W'(1)) begin
            s1_next.colpos = POS_L1;
        end else if (centre_col == COL_W'(FRAME_WIDTH - 2)) begin
            s1_next.colpos = POS_R1;
        end else if (centre_col == COL_W'(FRAME_WIDTH - 1)) begin
            s1_next.colpos = POS_R0;
        end else begin
            s1_next.colpos = POS_MID;
        end

        // window row m is raster row er-4+m, clamped into the frame
        for (int m = 0; m < LINE_SLOTS; m++) begin
            t = {1'b0, es} + (SLOT_W+1)'(m + 1);
            if (t >= (SLOT_W+1)'(LINE_SLOTS)) begin
                t = t - (SLOT_W+1)'(LINE_SLOTS);
            end
            if (er < ROW_W'(LINE_SLOTS - 1 - m)) begin
                s1_next.sel[m] = '0;
            end else if (({1'b0, er} + (ROW_W+1)'(m)) > (ROW_W+1)'(FRAME_HEIGHT + 3)) begin
                s1_next.sel[m] = SLOT_LAST;
            end else begin
                s1_next.sel[m] = t[SLOT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vr_reg <= '0;
            vc_reg <= '0;
            vs_reg <= '0;
        end else if (take) begin
            vr_reg <= vr_next;
            vc_reg <= vc_next;
            vs_reg <= vs_next;
        end
    end

    // ---------------- stages 1-3: line memory ----------------
    step_t      s1_reg;
    step_t      s2_reg;
    step_t      s3_reg;
    line_word_t line_mem [FRAME_WIDTH];
    line_word_t line_rd_reg;
    line_word_t merged;
    col_vec_t   vec3_next;
    col_vec_t   vec3_reg;

    always_comb begin
        merged = line_rd_reg;
        if (s2_reg.pixel) begin
            merged[s2_reg.wslot] = '{cur: s2_reg.cur, prev: s2_reg.prev, bg: s2_reg.bg};
        end
        for (int m = 0; m < LINE_SLOTS; m++) begin
            vec3_next.cur[m]  = merged[s2_reg.sel[m]].cur;
            vec3_next.prev[m] = merged[s2_reg.sel[m]].prev;
        end
        vec3_next.bg = merged[s2_reg.sel[MEDIAN_SIZE/2]].bg;
    end

    // column read-modify-write; the same column comes back FRAME_WIDTH steps on
    always_ff @(posedge aclk) begin
        if (en[2]) begin
            line_rd_reg <= line_mem[s1_reg.col];
        end
        if (en[3] && vld_reg[2] && s2_reg.pixel) begin
            line_mem[s2_reg.col] <= merged;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) s1_reg <= s1_next;
        if (en[2]) s2_reg <= s1_reg;
        if (en[3]) begin
            s3_reg   <= s2_reg;
            vec3_reg <= vec3_next;
        end
    end

    // ---------------- stage 4: column shift and window ----------------
    col_vec_t cs_reg [MEDIAN_SIZE-1];
    col_vec_t taps [MEDIAN_SIZE];
    window_t  win_cur_next;
    window_t  win_prev_next;
    window_t  win_cur_reg;
    window_t  win_prev_reg;
    pix_t     raw4_reg;
    pix_t     bg4_reg;
    logic     fe4_reg;

    always_comb begin
        for (int k = 0; k < MEDIAN_SIZE - 1; k++) begin
            taps[k] = cs_reg[k];
        end
        taps[MEDIAN_SIZE-1] = vec3_reg;
        for (int m = 0; m < MEDIAN_SIZE; m++) begin
            for (int r = 0; r < MEDIAN_SIZE; r++) begin
                win_cur_next[m*MEDIAN_SIZE + r]  = taps[tap_of(s3_reg.colpos, m)].cur[r];
                win_prev_next[m*MEDIAN_SIZE + r] = taps[tap_of(s3_reg.colpos, m)].prev[r];
            end
        end
    end

    // every step shifts the columns, emitting or not
    always_ff @(posedge aclk) begin
        if (en[4] && vld_reg[3]) begin
            for (int k = 0; k < MEDIAN_SIZE - 2; k++) begin
                cs_reg[k] <= cs_reg[k+1];
            end
            cs_reg[MEDIAN_SIZE-2] <= vec3_reg;
        end
        if (en[4]) begin
            win_cur_reg  <= win_cur_next;
            win_prev_reg <= win_prev_next;
            raw4_reg     <= taps[MEDIAN_SIZE/2].cur[MEDIAN_SIZE/2];
            bg4_reg      <= taps[MEDIAN_SIZE/2].bg;
            fe4_reg      <= s3_reg.frame_end;
        end
    end

    // ---------------- stages 5-7: medians ----------------
    med_ctl_t med_ctl;
    pix_t     med_cur;
    pix_t     med_prev;
    logic     bg_ok5_reg;
    logic     bg_ok6_reg;
    logic     bg_ok7_reg;
    logic     fe5_reg;
    logic     fe6_reg;
    logic     fe7_reg;

    assign med_ctl = '{en_cmp: en[5], en_rank: en[6], en_sel: en[7]};

    fdmm_median5x5 u_med_cur (
        .aclk   (aclk),
        .ctl    (med_ctl),
        .win    (win_cur_reg),
        .median (med_cur)
    );

    fdmm_median5x5 u_med_prev (
        .aclk   (aclk),
        .ctl    (med_ctl),
        .win    (win_prev_reg),
        .median (med_prev)
    );

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            bg_ok5_reg <= !bg_en_reg || (abs_diff(raw4_reg, bg4_reg) > bg_thr_reg);
            fe5_reg    <= fe4_reg;
        end
        if (en[6]) begin
            bg_ok6_reg <= bg_ok5_reg;
            fe6_reg    <= fe5_reg;
        end
        if (en[7]) begin
            bg_ok7_reg <= bg_ok6_reg;
            fe7_reg    <= fe6_reg;
        end
    end

    // ---------------- stage 8: decision / output register ----------------
    out_item_t out_next;
    out_item_t out_reg;

    assign out_next.motion    = (abs_diff(med_cur, med_prev) > diff_thr_reg) && bg_ok7_reg;
    assign out_next.frame_end = fe7_reg;

    always_ff @(posedge aclk) begin
        if (en[8]) out_reg <= out_next;
    end

    assign m_valid = vld_reg[8];
    assign m_data  = out_reg;

    // valids; non-emitting steps leave after the column shift
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[1]) vld_reg[1] <= take;
            if (en[2]) vld_reg[2] <= vld_reg[1];
            if (en[3]) vld_reg[3] <= vld_reg[2];
            if (en[4]) vld_reg[4] <= vld_reg[3] && s3_reg.emit;
            if (en[5]) vld_reg[5] <= vld_reg[4];
            if (en[6]) vld_reg[6] <= vld_reg[5];
            if (en[7]) vld_reg[7] <= vld_reg[6];
            if (en[8]) vld_reg[8] <= vld_reg[7];
        end
    end

    // ---------------- checks ----------------
    `FDMM_ASSERT_IMP(a_flush_emits, vld_reg[1] && !s1_reg.pixel, s1_reg.emit, "flush step without result")
    `FDMM_ASSERT_IMP(a_end_on_flush, vld_reg[1] && s1_reg.frame_end, !s1_reg.pixel, "frame end on pixel")
    `FDMM_ASSERT_IMP(a_pos_bound, 1'b1, vr_reg <= ROW_W'(FRAME_HEIGHT + 2), "row past drain tail")
    `FDMM_ASSERT_NEXT(a_win_hold, vld_reg[4] && !en[4], vld_reg[4] && $stable(win_cur_reg), "window lost in stall")

endmodule

// ===== sim/frame_difference_motion_mask_top_tb.sv =====
// Testbench for frame_difference_motion_mask_top: random and directed pixel streams,
// APB threshold writes and a self-checking mask predictor. Depends on fdmm_pkg and the RTL.
`timescale 1ns / 1ps

module frame_difference_motion_mask_top_tb;
    import fdmm_pkg::*;

    localparam int FRAME_PIXELS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int CENTRE_LAG   = 2 * FRAME_WIDTH + 2;
    localparam int BG_DEPTH     = 2 * FRAME_WIDTH + 3;
    localparam int STALL_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 24;

    // Predicts the mask bit for each centre pixel and keeps the pending masks in order.
    class mask_predictor;
        pix_t cur_rows [LINE_SLOTS*FRAME_WIDTH];
        pix_t prev_rows[LINE_SLOTS*FRAME_WIDTH];
        pix_t bg_line  [BG_DEPTH];
        int unsigned in_col, in_row, next_centre;
        pix_t diff_thr, bg_thr;
        logic bg_en;
        out_item_t pending_masks[$];
        int errors, masks_seen, frame_ends, flushes, writes;

        function new();
            in_col = 0; in_row = 0; next_centre = 0;
            diff_thr = DIFF_THR_RESET; bg_thr = BG_THR_RESET; bg_en = 1'b0;
            errors = 0; masks_seen = 0; frame_ends = 0; flushes = 0; writes = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [31:0] v);
            writes++;
            case (r)
                REG_DIFF_THR: diff_thr = v[7:0];
                REG_BG_THR:   bg_thr   = v[7:0];
                REG_BG_EN:    bg_en    = v[0];
                default: ;
            endcase
        endfunction

        function int unsigned median5(bit from_prev, int row, int col);
            int unsigned v[WIN_TAPS];
            int unsigned x;
            int n, rr, cc, j;
            n = 0;
            for (int dr = -2; dr <= 2; dr++) begin
                rr = row + dr;
                if (rr < 0) rr = 0;
                if (rr > FRAME_HEIGHT - 1) rr = FRAME_HEIGHT - 1;
                for (int dc = -2; dc <= 2; dc++) begin
                    cc = col + dc;
                    if (cc < 0) cc = 0;
                    if (cc > FRAME_WIDTH - 1) cc = FRAME_WIDTH - 1;
                    v[n] = from_prev ? prev_rows[(rr % LINE_SLOTS)*FRAME_WIDTH + cc]
                                     : cur_rows[(rr % LINE_SLOTS)*FRAME_WIDTH + cc];
                    n++;
                end
            end
            for (int i = 1; i < WIN_TAPS; i++) begin
                x = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > x) begin
                    v[j+1] = v[j];
                    j--;
                end
                v[j+1] = x;
            end
            return v[MEDIAN_RANK];
        endfunction

        function logic mask_at(int unsigned k);
            int row, col;
            int unsigned mc, mp, raw, bg, d;
            logic mark;
            row = k / FRAME_WIDTH;
            col = k % FRAME_WIDTH;
            mc = median5(1'b0, row, col);
            mp = median5(1'b1, row, col);
            d = (mc > mp) ? mc - mp : mp - mc;
            mark = d > diff_thr;
            if (bg_en) begin
                raw = cur_rows[(row % LINE_SLOTS)*FRAME_WIDTH + col];
                bg  = bg_line[k % BG_DEPTH];
                d = (raw > bg) ? raw - bg : bg - raw;
                mark = mark && (d > bg_thr);
            end
            return mark;
        endfunction

        function void take_request(in_item_t it);
            int unsigned pos, slot;
            out_item_t m;
            if (it.op == OP_PIXEL) begin
                pos  = in_row * FRAME_WIDTH + in_col;
                slot = (in_row % LINE_SLOTS) * FRAME_WIDTH + in_col;
                cur_rows[slot]  = it.current_pixel;
                prev_rows[slot] = it.previous_pixel;
                bg_line[pos % BG_DEPTH] = it.background_pixel;
                in_col++;
                if (in_col >= FRAME_WIDTH) begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= FRAME_HEIGHT) in_row = 0;
                end
                if (pos >= CENTRE_LAG) begin
                    m.motion = mask_at(pos - CENTRE_LAG);
                    m.frame_end = 1'b0;
                    pending_masks = {pending_masks, m};
                    next_centre = pos - CENTRE_LAG + 1;
                end else begin
                    next_centre = 0;
                end
            end else if (in_row == 0 && in_col == 0 && next_centre != 0
                         && next_centre < FRAME_PIXELS) begin
                // tail drain after a complete frame
                flushes++;
                m.motion = mask_at(next_centre);
                m.frame_end = (next_centre == FRAME_PIXELS - 1);
                pending_masks = {pending_masks, m};
                next_centre = m.frame_end ? 0 : next_centre + 1;
            end
        endfunction

        function void compare_mask(out_item_t got);
            out_item_t want;
            masks_seen++;
            if (got.frame_end) frame_ends++;
            if (pending_masks.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual motion=%0b frame_end=%0b",
                         $time, got.motion, got.frame_end);
                return;
            end
            want = pending_masks.pop_front();
            if (got.motion !== want.motion) begin
                errors++;
                $display("%0t: motion expected %0b actual %0b", $time, want.motion, got.motion);
            end
            if (got.frame_end !== want.frame_end) begin
                errors++;
                $display("%0t: frame_end expected %0b actual %0b",
                         $time, want.frame_end, got.frame_end);
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_item_t           s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_item_t          m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    mask_predictor predictor = new();
    int s_idle_pct = 0;
    int m_idle_pct = 0;
    int quiet_cycles = 0;
    int scene = 0;

    always #6 aclk = ~aclk;

    frame_difference_motion_mask_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Handshake monitor and randomised receiver back-pressure.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) predictor.take_request(s_data);
            if (m_valid && m_ready) predictor.compare_mask(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            m_ready <= ($urandom_range(99) >= m_idle_pct);
        end
    end

    // Watchdog: nothing moving for too long means a hang.
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge aclk);
        $display("frame_difference_motion_mask_top: mismatch");
        $finish;
    end

    task automatic send_request(in_item_t it);
        if ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < s_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_pixel(pix_t c, pix_t p, pix_t b);
        in_item_t it;
        it.op = OP_PIXEL;
        it.current_pixel = c;
        it.previous_pixel = p;
        it.background_pixel = b;
        send_request(it);
    endtask

    task automatic send_flush();
        in_item_t it;
        it = in_item_t'($urandom);
        it.op = OP_FLUSH;
        send_request(it);
    endtask

    // Random content: scenes switch between still, noisy and strongly changed regions.
    task automatic stream_pixels(int n, int flush_pct);
        int sent;
        int c, p, b;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(63) == 0) scene = $urandom_range(3);
            if (flush_pct > 0 && $urandom_range(99) < flush_pct) begin
                send_flush();
            end else begin
                c = $urandom_range(255);
                case (scene)
                    0: p = c + $urandom_range(16) - 8;
                    1: p = $urandom_range(255);
                    2: p = c ^ 8'h80;
                    default: p = 255 - c;
                endcase
                if (p < 0) p = 0;
                if (p > 255) p = 255;
                b = $urandom_range(1) ? $urandom_range(255) : c;
                send_pixel(pix_t'(c), pix_t'(p), pix_t'(b));
                sent++;
            end
        end
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_flushes(int n);
        repeat (n) send_flush();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every pending mask is back and the pipeline has emptied.
    task automatic settle();
        while (predictor.pending_masks.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(r));
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        predictor.set_reg(r, v);
    endtask

    task automatic configure(int dthr, int bthr, int en);
        settle();
        write_reg(REG_DIFF_THR, 32'(dthr));
        write_reg(REG_BG_THR, 32'(bthr));
        write_reg(REG_BG_EN, 32'(en));
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: flush with nothing pending, pixel extremes, flush mid-frame
        configure(0, 255, 1);
        send_flush();
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF);
        send_pixel(8'hFF, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hFF, 8'hFF);
        send_pixel(8'hAA, 8'h55, 8'hF0);
        send_pixel(8'h55, 8'hAA, 8'h0F);
        send_flush();
        send_pixel(8'h80, 8'h7F, 8'h01);
        send_pixel(8'h01, 8'hFE, 8'h80);
        s_valid <= 1'b0;
        @(posedge aclk);

        // sender idles lightly, receiver heavily
        s_idle_pct = 17; m_idle_pct = 57;
        configure(20, 0, 1);
        stream_pixels(800, 3);

        // roles swapped
        s_idle_pct = 57; m_idle_pct = 17;
        configure(255, 0, 0);
        stream_pixels(200, 3);
        configure(5, 10, 1);
        stream_pixels(200, 3);

        // full rate, extreme and mid thresholds, then stray flushes mid-frame
        s_idle_pct = 0; m_idle_pct = 0;
        configure(0, 0, 1);
        stream_pixels(240, 3);
        configure(12, 40, 1);
        stream_pixels(240, 3);
        send_flushes(2);

        settle();
        $display("Run covered %0d masks, %0d frame ends, %0d drain flushes, %0d register writes.",
                 predictor.masks_seen, predictor.frame_ends, predictor.flushes,
                 predictor.writes);
        if (predictor.errors == 0 && predictor.pending_masks.size() == 0) begin
            $display("frame_difference_motion_mask_top: match");
        end else begin
            $display("%0d errors, %0d masks never arrived",
                     predictor.errors, predictor.pending_masks.size());
            $display("frame_difference_motion_mask_top: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fdmm_pkg.sv
rtl/fdmm_median5x5.sv
rtl/frame_difference_motion_mask_top.sv
sim/frame_difference_motion_mask_top_tb.sv
